// ----- src/gwwb_pkg.sv -----
`default_nettype none

package gwwb_pkg;

    // Pixel channel width
    localparam int PIX_W = 8;
    // Running sum width, saturating
    localparam int SUM_W = 32;
    // Sum bias: 25.5 levels in half-level units
    localparam logic [SUM_W-1:0] SUM_BIAS = 32'd51;
    // Gain register ceiling after a division
    localparam int GAIN_SAT_W = 16;
    localparam logic [GAIN_SAT_W-1:0] GAIN_MAX = 16'hFFFF;
    // Default fraction bits of the gains
    localparam int GAIN_FRAC_BITS_DEF = 12;
    // Quotient bits produced by the divider (two above the saturated width)
    localparam int QUO_BITS = GAIN_SAT_W + 2;
    localparam int CNT_W = $clog2(QUO_BITS);
    // Width of the sum of all three channel sums
    localparam int ALL_W = SUM_W + 2;
    // Width of 3 * channel sum
    localparam int DEN_W = SUM_W + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALL,
        ST_DEN,
        ST_NUM,
        ST_DIV,
        ST_WR
    } t_state;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } t_chan;

    // Controller to datapath commands
    typedef struct packed {
        logic  acc;       // measure item accepted: add into the sums
        logic  adj;       // adjust item accepted: start the gain multiply
        logic  ld_all;    // register the total of the three sums
        logic  ld_den;    // register 3 * sum of the current channel
        logic  ld_num;    // load numerator and shifted divisor
        logic  div_step;  // one restoring division step
        logic  wr_gain;   // write the quotient into the channel gain
        logic  clr_sums;  // reload the sums with the bias
        t_chan ch;        // channel under division
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic pipe_rdy;   // adjust pipeline can take an item this cycle
    } t_stat;

endpackage

`default_nettype wire

// ----- src/gray_world_white_balance_top.sv -----
`default_nettype none

// Gray-world white balance for 8-bit RGB. Send a frame of measure items
// (tuser 0) and mark its final pixel with tlast: the block sums the channels
// and, after that final pixel, computes one 4.12-style gain per channel
// (GAIN_FRACTION_BITS fraction bits, saturating at 0xFFFF). Then send adjust
// items (tuser 1): each returns one corrected pixel, rounded to nearest and
// clamped to 255, with tlast copied. Measure items produce no output. Both
// kinds are taken at one item per cycle while no gain update runs and the
// adjust pipeline has room; adjust results pass through a two-register
// pipeline. After the last measure item, the input stalls while a single
// shared restoring divider, one quotient bit per cycle, computes the three
// gains (a channel total, then per channel a denominator, a numerator, 18
// steps and a gain write). Until a frame is measured the gains are unity.
module gray_world_white_balance_top #(
    parameter int GAIN_FRACTION_BITS = gwwb_pkg::GAIN_FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  wire logic        i_s_tuser,   // action: 0 measure, 1 adjust
    input  wire logic        i_s_tlast,   // last pixel of the frame in this pass
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic             o_m_tlast    // out_last
);
    import gwwb_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    gwwb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_action (i_s_tuser),
        .i_last   (i_s_tlast),
        .o_ready  (o_s_tready),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd)
    );

    gwwb_datapath #(
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_red   (i_s_tdata[7:0]),
        .i_green (i_s_tdata[15:8]),
        .i_blue  (i_s_tdata[23:16]),
        .i_last  (i_s_tlast),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_red   (o_m_tdata[7:0]),
        .o_green (o_m_tdata[15:8]),
        .o_blue  (o_m_tdata[23:16]),
        .o_last  (o_m_tlast)
    );

endmodule

`default_nettype wire

// ----- src/gwwb_ctrl.sv -----
`default_nettype none

module gwwb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_action,
    input  wire logic          i_last,
    output logic               o_ready,
    input  wire gwwb_pkg::t_stat i_stat,
    output gwwb_pkg::t_cmd     o_cmd
);
    import gwwb_pkg::*;

    t_state           r_state, n_state;
    t_chan            r_ch, n_ch;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_fire;

    // State, channel and step counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ch    <= CH_RED;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_cnt   <= n_cnt;
        end
    end

    assign o_ready = (r_state == ST_IDLE) && i_stat.pipe_rdy;
    assign w_fire  = i_valid && o_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.ch = r_ch;
        case (r_state)
            ST_IDLE: begin
                if (w_fire) begin
                    if (i_action) begin
                        o_cmd.adj = 1'b1;
                    end else begin
                        o_cmd.acc = 1'b1;
                        if (i_last) begin
                            n_state = ST_ALL;
                        end
                    end
                end
            end
            ST_ALL: begin
                o_cmd.ld_all = 1'b1;
                n_ch    = CH_RED;
                n_state = ST_DEN;
            end
            ST_DEN: begin
                o_cmd.ld_den = 1'b1;
                n_state = ST_NUM;
            end
            ST_NUM: begin
                o_cmd.ld_num = 1'b1;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(QUO_BITS - 1)) begin
                    n_state = ST_WR;
                end
            end
            ST_WR: begin
                o_cmd.wr_gain = 1'b1;
                if (r_ch == CH_BLUE) begin
                    o_cmd.clr_sums = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_ch    = t_chan'(r_ch + 2'd1);
                    n_state = ST_DEN;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // A last measure item always starts the gain update
    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !i_action && i_last) |=> (r_state == ST_ALL))
        else $error("last measure item did not start gain update");

    // Divider steps stay within the quotient width
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt < CNT_W'(QUO_BITS)))
        else $error("divider step count out of range");

    // Blue is the final channel; its write returns to idle
    a_blue_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR && r_ch == CH_BLUE) |=> (r_state == ST_IDLE))
        else $error("gain update did not end after blue");

endmodule

`default_nettype wire

// ----- src/gwwb_datapath.sv -----
`default_nettype none

module gwwb_datapath #(
    parameter int GAIN_FRACTION_BITS = gwwb_pkg::GAIN_FRAC_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire gwwb_pkg::t_cmd               i_cmd,
    output gwwb_pkg::t_stat                   o_stat,
    input  wire logic [gwwb_pkg::PIX_W-1:0]   i_red,
    input  wire logic [gwwb_pkg::PIX_W-1:0]   i_green,
    input  wire logic [gwwb_pkg::PIX_W-1:0]   i_blue,
    input  wire logic                         i_last,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [gwwb_pkg::PIX_W-1:0]        o_red,
    output logic [gwwb_pkg::PIX_W-1:0]        o_green,
    output logic [gwwb_pkg::PIX_W-1:0]        o_blue,
    output logic                              o_last
);
    import gwwb_pkg::*;

    localparam int F      = GAIN_FRACTION_BITS;
    // Gain register holds the unity value 2^F as well as the saturated ceiling
    localparam int GAIN_W = (F + 1 > GAIN_SAT_W) ? F + 1 : GAIN_SAT_W;
    localparam int PROD_W = PIX_W + GAIN_W;
    localparam int NUM_W  = ALL_W + F + 1;
    localparam int DIV_W  = DEN_W + QUO_BITS - 1;
    localparam int REM_W  = (NUM_W > DIV_W) ? NUM_W : DIV_W;
    localparam int HI_W   = PROD_W + 1 - F;
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << F;
    localparam logic [PROD_W:0]   ROUND_C  = (PROD_W + 1)'(1) << (F - 1);

    logic [SUM_W-1:0]    r_sum  [3];
    logic [GAIN_W-1:0]   r_gain [3];
    logic [ALL_W-1:0]    r_all;
    logic [DEN_W-1:0]    r_den;
    logic [REM_W-1:0]    r_rem;
    logic [REM_W-1:0]    r_div;
    logic [QUO_BITS-1:0] r_quo;
    logic [PROD_W-1:0]   r_prod [3];
    logic                r_p1_valid;
    logic                r_p1_last;
    logic                r_out_valid;
    logic [PIX_W-1:0]    r_out [3];
    logic                r_out_last;

    logic [PIX_W-1:0]    w_pix  [3];
    logic [SUM_W:0]      w_acc  [3];
    logic [PIX_W-1:0]    w_res  [3];
    logic [REM_W:0]      w_diff;
    logic [SUM_W-1:0]    w_own;
    logic [GAIN_W-1:0]   w_new_gain;
    logic                w_adv;

    assign w_pix[0] = i_red;
    assign w_pix[1] = i_green;
    assign w_pix[2] = i_blue;

    // Saturating accumulate of 2 * level
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_acc[c] = {1'b0, r_sum[c]} + (SUM_W + 1)'({w_pix[c], 1'b0});
        end
    end

    // Sums and gains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++) begin
                r_sum[c]  <= SUM_BIAS;
                r_gain[c] <= GAIN_ONE;
            end
        end else begin
            if (i_cmd.acc) begin
                for (int c = 0; c < 3; c++) begin
                    r_sum[c] <= w_acc[c][SUM_W] ? '1 : w_acc[c][SUM_W-1:0];
                end
            end
            if (i_cmd.clr_sums) begin
                for (int c = 0; c < 3; c++) begin
                    r_sum[c] <= SUM_BIAS;
                end
            end
            if (i_cmd.wr_gain) begin
                r_gain[i_cmd.ch] <= w_new_gain;
            end
        end
    end

    // Divider: restoring, one quotient bit per step, divisor shifts right
    assign w_own  = r_sum[i_cmd.ch];
    assign w_diff = {1'b0, r_rem} - {1'b0, r_div};
    assign w_new_gain = (|r_quo[QUO_BITS-1:GAIN_SAT_W]) ? GAIN_W'(GAIN_MAX)
                                                       : GAIN_W'(r_quo[GAIN_SAT_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_all) begin
            r_all <= ALL_W'(r_sum[0]) + ALL_W'(r_sum[1]) + ALL_W'(r_sum[2]);
        end
        if (i_cmd.ld_den) begin
            r_den <= DEN_W'(w_own) + DEN_W'({w_own, 1'b0});
        end
        if (i_cmd.ld_num) begin
            r_rem <= REM_W'({r_all, {F{1'b0}}}) + REM_W'(r_den >> 1);
            r_div <= REM_W'({r_den, {(QUO_BITS - 1){1'b0}}});
            r_quo <= '0;
        end
        if (i_cmd.div_step) begin
            if (!w_diff[REM_W]) begin
                r_rem <= w_diff[REM_W-1:0];
            end
            r_quo <= {r_quo[QUO_BITS-2:0], !w_diff[REM_W]};
            r_div <= r_div >> 1;
        end
    end

    // Adjust pipeline: multiply stage, then round/clamp into the output register
    assign w_adv           = !r_out_valid || i_ready;
    assign o_stat.pipe_rdy = !r_p1_valid || w_adv;

    always_comb begin
        logic [PROD_W:0] sum;
        logic [HI_W-1:0] hi;
        for (int c = 0; c < 3; c++) begin
            sum = {1'b0, r_prod[c]} + ROUND_C;
            hi  = sum[PROD_W:F];
            w_res[c] = (hi > HI_W'(255)) ? '1 : hi[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.adj) begin
                r_p1_valid <= 1'b1;
            end else if (w_adv) begin
                r_p1_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= r_p1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.adj) begin
            for (int c = 0; c < 3; c++) begin
                r_prod[c] <= PROD_W'(w_pix[c]) * PROD_W'(r_gain[c]);
            end
            r_p1_last <= i_last;
        end
        if (w_adv && r_p1_valid) begin
            for (int c = 0; c < 3; c++) begin
                r_out[c] <= w_res[c];
            end
            r_out_last <= r_p1_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];
    assign o_last  = r_out_last;

    // Controller never issues two of these commands at once (clr_sums comes with wr_gain)
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.acc, i_cmd.adj, i_cmd.ld_all, i_cmd.ld_den,
                  i_cmd.ld_num, i_cmd.div_step, i_cmd.wr_gain}))
        else $error("overlapping controller commands");

    // Sums are back at the bias after a gain update
    a_sums_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_sums |=> (r_sum[0] == SUM_BIAS && r_sum[1] == SUM_BIAS &&
                            r_sum[2] == SUM_BIAS))
        else $error("sums not reloaded with bias");

    // An adjust item is only taken when the pipeline has room
    a_adj_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.adj |-> o_stat.pipe_rdy)
        else $error("adjust item taken into full pipeline");

endmodule

`default_nettype wire

// ----- tb/sv/tb_gray_world_white_balance_top.sv -----
`default_nettype none

module tb_gray_world_white_balance_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gwwb_pkg::*;

    localparam int GFB         = GAIN_FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PRINT_LIMIT = 50;

    typedef enum logic {
        PIX_MEASURE = 1'b0,
        PIX_ADJUST  = 1'b1
    } t_pix_action;

    typedef struct {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             last;
    } t_corrected_pix;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;   // red[7:0], green[15:8], blue[23:16]
    logic        i_s_tuser = 1'b0; // action
    logic        i_s_tlast = 1'b0; // last pixel of the pass
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;        // out_red[7:0], out_green[15:8], out_blue[23:16]
    logic        o_m_tlast;        // out_last

    // Predictor state: channel sums and gains
    logic [SUM_W-1:0]      wb_sum_r, wb_sum_g, wb_sum_b;
    logic [GAIN_SAT_W-1:0] wb_gain_r, wb_gain_g, wb_gain_b;

    t_corrected_pix corrected_q[$];

    bit idle_en = 1'b1;
    int ready_hold = 0;
    int cycle_cnt = 0;
    int err_cnt = 0;
    int n_measure = 0;
    int n_adjust = 0;
    int n_frames = 0;
    int n_gain_sat = 0;
    int n_clamped = 0;
    int n_checked = 0;

    gray_world_white_balance_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("tb_gray_world_white_balance_top: errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= PRINT_LIMIT)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Saturating add of one channel, in half-level units
    function automatic logic [SUM_W-1:0] sum_add(input logic [SUM_W-1:0] sum,
                                                 input logic [PIX_W-1:0] level);
        logic [SUM_W:0] t;
        t = {1'b0, sum} + 2 * level;
        return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
    endfunction

    // Rounded (S_all << GFB) / (3 * S_c), saturating at the gain ceiling
    function automatic logic [GAIN_SAT_W-1:0] balance_gain(input logic [63:0] all,
                                                           input logic [SUM_W-1:0] own);
        logic [63:0] den, quo;
        den = 64'd3 * own;
        quo = ((all << GFB) + den / 2) / den;
        if (quo > {GAIN_SAT_W{1'b1}}) begin
            n_gain_sat++;
            return {GAIN_SAT_W{1'b1}};
        end
        return quo[GAIN_SAT_W-1:0];
    endfunction

    // Channel times gain, rounded and clamped to full scale
    function automatic logic [PIX_W-1:0] scale_level(input logic [PIX_W-1:0] level,
                                                     input logic [GAIN_SAT_W-1:0] gain);
        logic [63:0] p;
        p = (64'(level) * gain + (64'd1 << (GFB - 1))) >> GFB;
        if (p > 255) begin
            n_clamped++;
            return 8'd255;
        end
        return p[PIX_W-1:0];
    endfunction

    // Track one accepted pixel: update sums and gains or queue the corrected pixel
    task automatic predict_pixel(input t_pix_action act, input logic [PIX_W-1:0] r, g, b,
                                 input logic lst);
        logic [63:0]    all;
        t_corrected_pix px;
        if (act == PIX_MEASURE) begin
            n_measure++;
            wb_sum_r = sum_add(wb_sum_r, r);
            wb_sum_g = sum_add(wb_sum_g, g);
            wb_sum_b = sum_add(wb_sum_b, b);
            if (lst) begin
                n_frames++;
                all = 64'(wb_sum_r) + wb_sum_g + wb_sum_b;
                wb_gain_r = balance_gain(all, wb_sum_r);
                wb_gain_g = balance_gain(all, wb_sum_g);
                wb_gain_b = balance_gain(all, wb_sum_b);
                wb_sum_r = SUM_BIAS;
                wb_sum_g = SUM_BIAS;
                wb_sum_b = SUM_BIAS;
            end
        end else begin
            n_adjust++;
            px.red   = scale_level(r, wb_gain_r);
            px.green = scale_level(g, wb_gain_g);
            px.blue  = scale_level(b, wb_gain_b);
            px.last  = lst;
            corrected_q.push_back(px);
        end
    endtask

    // Send one pixel; tvalid stays high into the next call unless a gap is taken
    task automatic send_pixel(input t_pix_action act, input logic [PIX_W-1:0] r, g, b,
                              input logic lst);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 3);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= {b, g, r};
        i_s_tlast  <= lst;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_pixel(act, r, g, b, lst);
    endtask

    // Hold off the sender until every corrected pixel has come back
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (corrected_q.size() != 0) @(posedge i_clk);
    endtask

    // Output check and random backpressure
    always @(posedge i_clk) begin : out_check
        t_corrected_pix want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (corrected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel tdata=%h tlast=%b",
                                          o_m_tdata, o_m_tlast));
            end else begin
                want = corrected_q.pop_front();
                n_checked++;
                if (o_m_tdata[7:0] !== want.red)
                    report_mismatch($sformatf("out_red got %0d want %0d",
                                              o_m_tdata[7:0], want.red));
                if (o_m_tdata[15:8] !== want.green)
                    report_mismatch($sformatf("out_green got %0d want %0d",
                                              o_m_tdata[15:8], want.green));
                if (o_m_tdata[23:16] !== want.blue)
                    report_mismatch($sformatf("out_blue got %0d want %0d",
                                              o_m_tdata[23:16], want.blue));
                if (o_m_tlast !== want.last)
                    report_mismatch($sformatf("out_last got %b want %b",
                                              o_m_tlast, want.last));
            end
        end
        if (ready_hold > 0) begin
            ready_hold--;
            i_m_tready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            ready_hold = $urandom_range(0, 2);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Adjust before any frame is measured: gains are unity
    task automatic test_unity_gains();
        send_pixel(PIX_ADJUST, 8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(PIX_ADJUST, 8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(PIX_ADJUST, 8'd1, 8'd128, 8'd254, 1'b0);
        send_pixel(PIX_ADJUST, 8'd170, 8'd85, 8'd15, 1'b1);
    endtask

    // Hand-picked frames: black, a dead channel that saturates its gain, casts
    task automatic test_directed_frames();
        // single black pixel: only the bias counts, gains stay unity
        send_pixel(PIX_MEASURE, 8'd0, 8'd0, 8'd0, 1'b1);
        send_pixel(PIX_ADJUST, 8'd255, 8'd0, 8'd128, 1'b1);
        // red dead over three pixels: red gain hits the ceiling
        repeat (2) send_pixel(PIX_MEASURE, 8'd0, 8'd255, 8'd255, 1'b0);
        send_pixel(PIX_MEASURE, 8'd0, 8'd255, 8'd255, 1'b1);
        send_pixel(PIX_ADJUST, 8'd255, 8'd1, 8'd255, 1'b0);
        send_pixel(PIX_ADJUST, 8'd1, 8'd255, 8'd0, 1'b1);
        // neutral gray frame
        send_pixel(PIX_MEASURE, 8'd200, 8'd200, 8'd200, 1'b0);
        send_pixel(PIX_MEASURE, 8'd200, 8'd200, 8'd200, 1'b1);
        send_pixel(PIX_ADJUST, 8'd100, 8'd255, 8'd3, 1'b1);
        // strong red cast, blue empty
        send_pixel(PIX_MEASURE, 8'd255, 8'd128, 8'd0, 1'b0);
        send_pixel(PIX_MEASURE, 8'd255, 8'd128, 8'd0, 1'b1);
        send_pixel(PIX_ADJUST, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(PIX_ADJUST, 8'd0, 8'd0, 8'd0, 1'b1);
        send_pixel(PIX_ADJUST, 8'd127, 8'd64, 8'd2, 1'b0);
        drain_results();
    endtask

    // Random frames with color casts; some passes interleaved or broken
    task automatic test_random_frames(input int target);
        int start, len, i, lo_r, lo_g, lo_b, hi_r, hi_g, hi_b;
        bit mixed;
        start = n_measure + n_adjust;
        while (n_measure + n_adjust - start < target) begin
            hi_r = $urandom_range(0, 255);
            hi_g = $urandom_range(0, 255);
            hi_b = $urandom_range(0, 255);
            lo_r = ($urandom_range(0, 7) == 0) ? hi_r : $urandom_range(0, hi_r);
            lo_g = ($urandom_range(0, 7) == 0) ? hi_g : $urandom_range(0, hi_g);
            lo_b = ($urandom_range(0, 7) == 0) ? hi_b : $urandom_range(0, hi_b);
            mixed = ($urandom_range(0, 5) == 0);
            len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 24);
            for (i = 0; i < len; i++) begin
                if (mixed && $urandom_range(0, 3) == 0)
                    send_pixel(PIX_ADJUST, 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)));
                send_pixel(PIX_MEASURE, 8'($urandom_range(lo_r, hi_r)),
                           8'($urandom_range(lo_g, hi_g)), 8'($urandom_range(lo_b, hi_b)),
                           1'(i == len - 1));
            end
            len = $urandom_range(1, 24);
            for (i = 0; i < len; i++)
                send_pixel(PIX_ADJUST, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           1'(i == len - 1 || $urandom_range(0, 7) == 0));
            if ($urandom_range(0, 15) == 0)
                drain_results();
        end
    endtask

    // Back-to-back frames with no idling on either side
    task automatic test_steady_stream(input int target);
        int start, len, i;
        idle_en = 1'b0;
        start = n_measure + n_adjust;
        while (n_measure + n_adjust - start < target) begin
            len = $urandom_range(1, 16);
            for (i = 0; i < len; i++)
                send_pixel(PIX_MEASURE, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           1'(i == len - 1));
            len = $urandom_range(1, 16);
            for (i = 0; i < len; i++)
                send_pixel(PIX_ADJUST, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           1'(i == len - 1));
        end
    endtask

    initial begin
        t_corrected_pix left;
        wb_sum_r  = SUM_BIAS;
        wb_sum_g  = SUM_BIAS;
        wb_sum_b  = SUM_BIAS;
        wb_gain_r = GAIN_SAT_W'(1 << GFB);
        wb_gain_g = GAIN_SAT_W'(1 << GFB);
        wb_gain_b = GAIN_SAT_W'(1 << GFB);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_unity_gains();
        test_directed_frames();
        test_random_frames(1300);
        test_steady_stream(200);

        // wait out the output pipeline
        drain_results();
        repeat (8) @(posedge i_clk);
        while (corrected_q.size() != 0) begin
            left = corrected_q.pop_front();
            report_mismatch($sformatf("missing pixel %0d/%0d/%0d last %b",
                                      left.red, left.green, left.blue, left.last));
        end

        $display("covered %0d measure and %0d adjust pixels, %0d checked, %0d frames",
                 n_measure, n_adjust, n_checked, n_frames);
        $display("gain ceiling hit %0d times, output clamped %0d times, %0d mismatches",
                 n_gain_sat, n_clamped, err_cnt);
        if (err_cnt == 0) begin
            $display("tb_gray_world_white_balance_top: clean");
        end else begin
            $display("tb_gray_world_white_balance_top: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
src/gwwb_pkg.sv
src/gwwb_ctrl.sv
src/gwwb_datapath.sv
src/gray_world_white_balance_top.sv
tb/sv/tb_gray_world_white_balance_top.sv
